// ----- sv/assert_macros.svh -----
// Assertion macros used by the top-level RTL file of the codec.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property that must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed: always");

// Same-cycle implication.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: implication");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next cycle");

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ----- sv/b64_pkg.sv -----
// Shared constants, alphabet tables and types of the base64 codec.
`timescale 1ns / 1ps
`default_nettype none

package b64_pkg;

  localparam int unsigned NUM_TABLES = 7;

  localparam logic [7:0] PAD_CHAR     = 8'h3D;
  localparam logic [5:0] UU_PAD_VALUE = 6'd29;

  // Alphabet variant codes.
  localparam logic [3:0] VAR_STD      = 4'd0;
  localparam logic [3:0] VAR_URL      = 4'd1;
  localparam logic [3:0] VAR_MIME     = 4'd2;
  localparam logic [3:0] VAR_UTF7     = 4'd3;
  localparam logic [3:0] VAR_UUENCODE = 4'd4;
  localparam logic [3:0] VAR_BINHEX4  = 4'd5;
  localparam logic [3:0] VAR_CRYPT    = 4'd6;
  localparam logic [3:0] VAR_BCRYPT   = 4'd7;
  localparam logic [3:0] VAR_BASH     = 4'd8;

  localparam logic DIR_ENCODE = 1'b0;
  localparam logic DIR_DECODE = 1'b1;

  // Configuration register indexes.
  localparam logic CFG_ALPHABET  = 1'b0;
  localparam logic CFG_DIRECTION = 1'b1;

  localparam int unsigned CFG_INDEX_W = 1;
  localparam int unsigned CFG_DATA_W  = 4;

  typedef logic [511:0] alpha_row_t;

  // Character i of a row sits in bits [511-8i -: 8].
  localparam alpha_row_t ALPHA_ROM [NUM_TABLES] = '{
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/",
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789-_",
    " !\"#$%&'()*+,-./0123456789:;<=>?@ABCDEFGHIJKLMNOPQRSTUVWXYZ[\\]^_",
    "!\"#$%&'()*+,-012345689@ABCDEFGHIJKLMNPQRSTUVXYZ[`abcdefhijklmpqr",
    "./0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz",
    "./ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789",
    "0123456789abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ@_"
  };

  // Up to four result beats produced by one input beat, first in bytes[0].
  typedef struct packed {
    logic [2:0]       cnt;
    logic             err;
    logic             eom;
    logic [3:0][7:0]  bytes;
  } res_t;

  function automatic logic [2:0] table_sel(input logic [3:0] variant);
    logic [2:0] sel;
    unique case (variant)
      VAR_STD, VAR_URL: sel = (variant == VAR_URL) ? 3'd1 : 3'd0;
      VAR_MIME:         sel = 3'd0;
      VAR_UTF7:         sel = 3'd0;
      VAR_UUENCODE:     sel = 3'd2;
      VAR_BINHEX4:      sel = 3'd3;
      VAR_CRYPT:        sel = 3'd4;
      VAR_BCRYPT:       sel = 3'd5;
      VAR_BASH:         sel = 3'd6;
      default:          sel = 3'd0;
    endcase
    return sel;
  endfunction

  function automatic logic [7:0] enc_char(input logic [2:0] tsel, input logic [5:0] idx);
    alpha_row_t row;
    row = ALPHA_ROM[tsel];
    return row[{~idx, 3'b000} +: 8];
  endfunction

  // Returns {hit, value}; bytes with bit 7 set never match.
  function automatic logic [6:0] dec_lookup(input logic [2:0] tsel, input logic [7:0] c);
    alpha_row_t row;
    logic [6:0] hit;
    row = ALPHA_ROM[tsel];
    hit = '0;
    for (int i = 0; i < 64; i++) begin
      if (!c[7] && row[8*(63-i) +: 8] == c) begin
        hit = {1'b1, 6'(i)};
      end
    end
    return hit;
  endfunction

endpackage

`default_nettype wire

// ----- sv/b64_core.sv -----
// Group state and combinational encode/decode step of the base64 codec.
`timescale 1ns / 1ps
`default_nettype none

module b64_core (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          clr,
  input  wire logic          step,
  input  wire logic [7:0]    data,
  input  wire logic          last,
  input  wire logic [3:0]    variant,
  input  wire logic          dir,
  output b64_pkg::res_t      res
);

  logic [23:0] gv_r, gv_nxt;
  logic [1:0]  fill_r, fill_nxt;
  logic        pad3_r, pad3_nxt;
  logic        disc_r, disc_nxt;

  logic [2:0]  tsel;
  logic [1:0]  pos;
  logic [23:0] gv_e;
  logic [2:0]  n_e;
  logic [2:0]  chars;
  logic [6:0]  lk;
  logic        uu;
  logic        pad;
  logic        err;
  logic [1:0]  n_d;
  logic [2:0]  held;

  assign tsel = b64_pkg::table_sel(variant);
  assign lk   = b64_pkg::dec_lookup(tsel, data);
  assign uu   = (variant == b64_pkg::VAR_UUENCODE);
  assign pad  = !uu && (data == b64_pkg::PAD_CHAR);

  always_comb begin
    gv_nxt   = gv_r;
    fill_nxt = fill_r;
    pad3_nxt = pad3_r;
    disc_nxt = disc_r;
    res      = '0;
    pos      = fill_r;
    gv_e     = gv_r;
    n_e      = 3'd0;
    chars    = 3'd0;
    err      = 1'b0;
    n_d      = 2'd0;
    held     = {1'b0, fill_r} + 3'd1;

    if (dir == b64_pkg::DIR_ENCODE) begin
      pos = (fill_r == 2'd3) ? 2'd2 : fill_r;
      case (pos)
        2'd0:    gv_e = gv_r | {data, 16'h0000};
        2'd1:    gv_e = gv_r | {8'h00, data, 8'h00};
        default: gv_e = gv_r | {16'h0000, data};
      endcase
      n_e = {1'b0, pos} + 3'd1;
      if (n_e < 3'd3 && !last) begin
        gv_nxt   = gv_e;
        fill_nxt = n_e[1:0];
      end else begin
        chars = (n_e == 3'd3) ? 3'd4 : n_e + 3'd1;
        for (int k = 0; k < 4; k++) begin
          if (3'(k) < chars) begin
            res.bytes[k] = b64_pkg::enc_char(tsel, gv_e[18-6*k +: 6]);
          end else begin
            res.bytes[k] = b64_pkg::PAD_CHAR;
          end
        end
        res.cnt  = (variant == b64_pkg::VAR_MIME) ? 3'd4 : chars;
        res.eom  = last;
        gv_nxt   = '0;
        fill_nxt = '0;
        pad3_nxt = 1'b0;
      end
    end else if (disc_r) begin
      // Rest of a failed message is dropped up to its last beat.
      if (last) begin
        disc_nxt = 1'b0;
        gv_nxt   = '0;
        fill_nxt = '0;
        pad3_nxt = 1'b0;
      end
    end else begin
      if (fill_r != 2'd3) begin
        if (fill_r == 2'd2 && pad) begin
          pad3_nxt = 1'b1;
        end else if (!lk[6]) begin
          err = 1'b1;
        end else begin
          case (fill_r)
            2'd0:    gv_e = gv_r | {lk[5:0], 18'h0};
            2'd1:    gv_e = gv_r | {6'h0, lk[5:0], 12'h0};
            default: gv_e = gv_r | {12'h0, lk[5:0], 6'h0};
          endcase
        end
      end else if (pad3_r) begin
        if (pad) n_d = 2'd1;
        else     err = 1'b1;
      end else if (pad) begin
        n_d = 2'd2;
      end else if (!lk[6]) begin
        err = 1'b1;
      end else begin
        gv_e = gv_r | {18'h0, lk[5:0]};
        n_d  = 2'd3;
      end

      // Message ends inside a group: finish it as if padded.
      if (!err && n_d == 2'd0 && last) begin
        if (uu) begin
          if (held <= 3'd1) gv_e[11:6] = gv_e[11:6] | b64_pkg::UU_PAD_VALUE;
          if (held <= 3'd2) gv_e[11:6] = gv_e[11:6];
          if (held <= 3'd1) gv_e[17:12] = gv_e[17:12] | b64_pkg::UU_PAD_VALUE;
          if (held <= 3'd2) gv_e[11:6]  = gv_e[11:6] | b64_pkg::UU_PAD_VALUE;
          gv_e[5:0] = gv_e[5:0] | b64_pkg::UU_PAD_VALUE;
          n_d = 2'd3;
        end else if (held == 3'd1) begin
          err = 1'b1;
        end else if (held == 3'd2 || pad3_nxt) begin
          n_d = 2'd1;
        end else begin
          n_d = 2'd2;
        end
      end

      if (err) begin
        res.cnt  = 3'd1;
        res.err  = 1'b1;
        res.eom  = last;
        disc_nxt = !last;
        gv_nxt   = '0;
        fill_nxt = '0;
        pad3_nxt = 1'b0;
      end else if (n_d == 2'd0) begin
        gv_nxt   = gv_e;
        fill_nxt = held[1:0];
      end else begin
        res.bytes[0] = gv_e[23:16];
        res.bytes[1] = gv_e[15:8];
        res.bytes[2] = gv_e[7:0];
        res.cnt      = {1'b0, n_d};
        res.eom      = last;
        gv_nxt       = '0;
        fill_nxt     = '0;
        pad3_nxt     = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      gv_r   <= '0;
      fill_r <= '0;
      pad3_r <= 1'b0;
      disc_r <= 1'b0;
    end else if (step) begin
      gv_r   <= gv_nxt;
      fill_r <= fill_nxt;
      pad3_r <= pad3_nxt;
      disc_r <= disc_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- sv/b64_obuf.sv -----
// Result register that hands out up to four result beats of one input beat.
`timescale 1ns / 1ps
`default_nettype none

module b64_obuf (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          load,
  input  wire b64_pkg::res_t res,
  output logic               can_load,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [7:0]         out_byte,
  output logic               out_last,
  output logic               out_eom,
  output logic               out_err
);

  logic [3:0][7:0] byte_r, byte_nxt;
  logic [2:0]      rem_r, rem_nxt;
  logic            eom_r, eom_nxt;
  logic            err_r, err_nxt;
  logic            pop;

  assign out_valid = (rem_r != 3'd0);
  assign pop       = out_valid && out_ready;
  assign can_load  = (rem_r == 3'd0) || (rem_r == 3'd1 && out_ready);
  assign out_byte  = byte_r[0];
  assign out_last  = (rem_r == 3'd1);
  assign out_eom   = eom_r && out_last;
  assign out_err   = err_r;

  always_comb begin
    byte_nxt = byte_r;
    rem_nxt  = rem_r;
    eom_nxt  = eom_r;
    err_nxt  = err_r;
    if (load && res.cnt != 3'd0) begin
      byte_nxt = res.bytes;
      rem_nxt  = res.cnt;
      eom_nxt  = res.eom;
      err_nxt  = res.err;
    end else if (pop) begin
      byte_nxt = {8'h00, byte_r[3:1]};
      rem_nxt  = rem_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= '0;
    end else begin
      rem_r <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    eom_r  <= eom_nxt;
    err_r  <= err_nxt;
  end

endmodule

`default_nettype wire

// ----- sv/base64_multi_alphabet_codec.sv -----
// An accepted input beat is held in the input register, then its results go to the result register.
// Throughput: one input beat per cycle while the result register can take it; a beat that
// yields k results holds the output register until all k are taken, so the result port sets the pace.
// Reset (rst_n low at a clock edge) clears the group state, the registers and both stages.
// A configuration write also clears the group state.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module base64_multi_alphabet_codec (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_tvalid,
  output logic                                      in_tready,
  input  wire logic [7:0]                           in_tdata,   // data_byte
  input  wire logic                                 in_tlast,   // last_of_message
  output logic                                      out_tvalid,
  input  wire logic                                 out_tready,
  output logic [7:0]                                out_tdata,  // out_byte
  output logic                                      out_tlast,  // last_of_run
  output logic [1:0]                                out_tuser,  // end_of_message, decode_error
  input  wire logic                                 cfg_we,
  input  wire logic [b64_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  wire logic [b64_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

  logic [3:0]     variant_r;
  logic           dir_r;
  logic           in_valid_r;
  logic [7:0]     in_data_r;
  logic           in_last_r;
  logic           can_load;
  logic           proc;
  b64_pkg::res_t  res;
  logic           o_eom;
  logic           o_err;

  assign proc      = in_valid_r && can_load;
  assign in_tready = !in_valid_r || proc;
  assign out_tuser = {o_err, o_eom};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      variant_r <= b64_pkg::VAR_STD;
      dir_r     <= b64_pkg::DIR_ENCODE;
    end else if (cfg_we) begin
      case (cfg_index)
        b64_pkg::CFG_ALPHABET:  variant_r <= cfg_wdata[3:0];
        b64_pkg::CFG_DIRECTION: dir_r     <= cfg_wdata[0];
        default:                ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_data_r <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  b64_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .clr     (cfg_we),
    .step    (proc),
    .data    (in_data_r),
    .last    (in_last_r),
    .variant (variant_r),
    .dir     (dir_r),
    .res     (res)
  );

  b64_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (proc),
    .res       (res),
    .can_load  (can_load),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_byte  (out_tdata),
    .out_last  (out_tlast),
    .out_eom   (o_eom),
    .out_err   (o_err)
  );

  // Errors come only from the decoder and always stand alone as the last beat.
  `ASSERT_IMPLIES(a_err_decode_only, clk, rst_n, out_tvalid && out_tuser[1], dir_r == b64_pkg::DIR_DECODE)
  `ASSERT_IMPLIES(a_err_single, clk, rst_n, out_tvalid && out_tuser[1], out_tlast)
  `ASSERT_IMPLIES(a_eom_on_last, clk, rst_n, out_tvalid && out_tuser[0], out_tlast)
  // A held input beat that could not advance is still held in the next cycle.
  `ASSERT_NEXT(a_in_held, clk, rst_n, in_valid_r && !proc, in_valid_r)

endmodule

`default_nettype wire

// ----- verif/tb.sv -----
// Self-checking testbench of the base64 codec: directed cases, then random messages under stalls.
`timescale 1ns / 1ps

module tb;

  localparam int RANDOM_ITEMS = 480;
  localparam int LONG_HOLD    = 150;
  localparam int STALL_LIMIT  = 2000;

  typedef struct packed {
    logic [7:0] ch;
    logic       run_end;
    logic       msg_end;
    logic       err;
  } codec_beat_t;

  class codec_scoreboard;
    codec_beat_t expected_beats[$];
    logic [7:0]  out_bytes[$];
    string       alphabets[7];
    int          errors;
    logic [3:0]  variant;
    logic        dir;
    logic [23:0] acc;
    logic [1:0]  fill;
    logic        pad3;
    logic        skip;

    function new();
      alphabets[0] = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
      alphabets[1] = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789-_";
      alphabets[2] = " !\"#$%&'()*+,-./0123456789:;<=>?@ABCDEFGHIJKLMNOPQRSTUVWXYZ[\\]^_";
      alphabets[3] = "!\"#$%&'()*+,-012345689@ABCDEFGHIJKLMNPQRSTUVXYZ[`abcdefhijklmpqr";
      alphabets[4] = "./0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz";
      alphabets[5] = "./ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789";
      alphabets[6] = "0123456789abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ@_";
      errors  = 0;
      variant = b64_pkg::VAR_STD;
      dir     = b64_pkg::DIR_ENCODE;
      skip    = 1'b0;
      clear_group();
    endfunction

    function void clear_group();
      acc  = '0;
      fill = '0;
      pad3 = 1'b0;
    endfunction

    // Unknown variant codes fall back to the standard table.
    function int table_of();
      case (variant)
        b64_pkg::VAR_URL:      return 1;
        b64_pkg::VAR_UUENCODE: return 2;
        b64_pkg::VAR_BINHEX4:  return 3;
        b64_pkg::VAR_CRYPT:    return 4;
        b64_pkg::VAR_BCRYPT:   return 5;
        b64_pkg::VAR_BASH:     return 6;
        default:               return 0;
      endcase
    endfunction

    function logic [7:0] char_at(int idx);
      return alphabets[table_of()].getc(idx);
    endfunction

    function int char_value(logic [7:0] c);
      if (c[7]) return -1;
      for (int i = 0; i < 64; i++) begin
        if (char_at(i) == c) return i;
      end
      return -1;
    endfunction

    function void write_reg(logic [b64_pkg::CFG_INDEX_W-1:0] idx,
                            logic [b64_pkg::CFG_DATA_W-1:0] value);
      if (idx == b64_pkg::CFG_ALPHABET) begin
        variant = value;
      end else begin
        dir = value[0];
      end
      clear_group();
      skip = 1'b0;
    endfunction

    // Moves the bytes built for one input beat into the expected stream.
    function void flush(logic msg_last, logic err);
      codec_beat_t b;
      for (int i = 0; i < out_bytes.size(); i++) begin
        b.ch      = out_bytes[i];
        b.run_end = (i == out_bytes.size() - 1);
        b.msg_end = b.run_end && msg_last;
        b.err     = err;
        expected_beats.push_back(b);
      end
      out_bytes.delete();
    endfunction

    function void encode_byte(logic [7:0] c, logic l);
      int pos;
      int n;
      int chars;
      pos = fill;
      if (pos > 2) pos = 2;
      acc = acc | (24'(c) << (16 - 8 * pos));
      n = pos + 1;
      if (n < 3 && !l) begin
        fill = 2'(n);
        return;
      end
      chars = (n == 3) ? 4 : n + 1;
      for (int k = 0; k < 4; k++) begin
        if (k < chars) begin
          out_bytes.push_back(char_at(int'(6'(acc >> (18 - 6 * k)))));
        end else if (variant == b64_pkg::VAR_MIME) begin
          out_bytes.push_back(b64_pkg::PAD_CHAR);
        end
      end
      clear_group();
      flush(l, 1'b0);
    endfunction

    function void decode_char(logic [7:0] c, logic l);
      int   pos;
      int   n;
      int   v;
      int   held;
      logic uu;
      logic pad;
      logic err;
      pos = fill;
      uu  = (variant == b64_pkg::VAR_UUENCODE);
      pad = !uu && (c == b64_pkg::PAD_CHAR);
      err = 1'b0;
      n   = 0;
      if (skip) begin
        if (l) begin
          skip = 1'b0;
          clear_group();
        end
        return;
      end
      if (pos < 3) begin
        if (pos == 2 && pad) begin
          pad3 = 1'b1;
        end else begin
          v = char_value(c);
          if (v < 0) err = 1'b1;
          else acc = acc | (24'(v) << (18 - 6 * pos));
        end
      end else if (pad3) begin
        if (pad) n = 1;
        else err = 1'b1;
      end else if (pad) begin
        n = 2;
      end else begin
        v = char_value(c);
        if (v < 0) begin
          err = 1'b1;
        end else begin
          acc = acc | 24'(v);
          n = 3;
        end
      end
      // A message that ends inside a group completes it implicitly.
      if (!err && n == 0 && l) begin
        held = pos + 1;
        if (uu) begin
          for (int p = held; p < 4; p++) begin
            acc = acc | (24'(b64_pkg::UU_PAD_VALUE) << (18 - 6 * p));
          end
          n = 3;
        end else if (held == 1) begin
          err = 1'b1;
        end else if (held == 2 || pad3) begin
          n = 1;
        end else begin
          n = 2;
        end
      end
      if (err) begin
        out_bytes.push_back(8'h00);
        flush(l, 1'b1);
        skip = !l;
        clear_group();
        return;
      end
      if (n == 0) begin
        fill = 2'(pos + 1);
        return;
      end
      for (int k = 0; k < n; k++) out_bytes.push_back(8'(acc >> (16 - 8 * k)));
      clear_group();
      flush(l, 1'b0);
    endfunction

    function void note_input(logic [7:0] c, logic l);
      if (dir == b64_pkg::DIR_DECODE) decode_char(c, l);
      else encode_byte(c, l);
    endfunction

    function void check_result(logic [7:0] ch, logic run_end, logic msg_end, logic err);
      codec_beat_t want;
      if (expected_beats.size() == 0) begin
        $error("unexpected result beat: out_byte=%02h", ch);
        errors++;
        return;
      end
      want = expected_beats.pop_front();
      if (ch !== want.ch) begin
        $error("out_byte: expected %02h, got %02h", want.ch, ch);
        errors++;
      end
      if (run_end !== want.run_end) begin
        $error("last_of_run: expected %0b, got %0b", want.run_end, run_end);
        errors++;
      end
      if (msg_end !== want.msg_end) begin
        $error("end_of_message: expected %0b, got %0b", want.msg_end, msg_end);
        errors++;
      end
      if (err !== want.err) begin
        $error("decode_error: expected %0b, got %0b", want.err, err);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [7:0] in_tdata = '0;
  logic in_tlast = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [7:0] out_tdata;   // out_byte
  logic out_tlast;         // last_of_run
  logic [1:0] out_tuser;   // end_of_message, decode_error
  logic cfg_we = 1'b0;
  logic [b64_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [b64_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  codec_scoreboard sb = new();
  logic [7:0] msg[$];
  int  sent_items = 0;
  int  hold_reqs = 0;
  int  quiet_cycles = 0;
  bit  quiet = 1'b0;

  base64_multi_alphabet_codec uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The receiver runs a long hold-off each time the stimulus asks for one.
  initial begin : receiver
    int hold_left;
    int reqs_seen;
    hold_left = 0;
    reqs_seen = 0;
    forever begin
      @(negedge clk);
      if (reqs_seen != hold_reqs) begin
        reqs_seen = hold_reqs;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= quiet || ($urandom_range(99) >= 18);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_result(out_tdata, out_tlast, out_tuser[0], out_tuser[1]);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Called and returns at a falling edge; valid stays up once offered.
  task automatic send_beat(input logic [7:0] d, input logic l);
    logic done;
    logic offered;
    done    = 1'b0;
    offered = 1'b0;
    while (!done) begin
      if (!offered && !quiet && $urandom_range(99) < 18) begin
        in_tvalid <= 1'b0;
      end else begin
        in_tvalid <= 1'b1;
        in_tdata  <= d;
        in_tlast  <= l;
        offered = 1'b1;
      end
      @(posedge clk);
      if (in_tvalid && in_tready) begin
        sb.note_input(d, l);
        sent_items++;
        done = 1'b1;
      end
      @(negedge clk);
    end
  endtask

  task automatic send_msg();
    for (int i = 0; i < msg.size(); i++) send_beat(msg[i], i == msg.size() - 1);
  endtask

  task automatic send_text(input string s);
    msg.delete();
    for (int i = 0; i < s.len(); i++) msg.push_back(s.getc(i));
    send_msg();
  endtask

  // A beat that yields nothing may still be in the pipeline; wait past the latency.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (sb.expected_beats.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_mode(input logic [3:0] variant, input logic dir);
    logic [b64_pkg::CFG_DATA_W-1:0] dir_word;
    dir_word = {3'($urandom), dir};
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= b64_pkg::CFG_ALPHABET;
    cfg_wdata <= variant;
    @(negedge clk);
    cfg_index <= b64_pkg::CFG_DIRECTION;
    cfg_wdata <= dir_word;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(b64_pkg::CFG_ALPHABET, variant);
    sb.write_reg(b64_pkg::CFG_DIRECTION, dir_word);
  endtask

  task automatic build_plain();
    int len;
    len = $urandom_range(1, 7);
    msg.delete();
    repeat (len) msg.push_back(8'($urandom_range(255)));
  endtask

  // Mostly well-formed groups with random content; some messages get corrupted.
  task automatic build_encoded(input logic [3:0] variant);
    int   groups;
    int   kind;
    int   nchars;
    int   r;
    logic uu;
    uu = (variant == b64_pkg::VAR_UUENCODE);
    groups = $urandom_range(1, 3);
    msg.delete();
    for (int g = 0; g < groups; g++) begin
      kind = $urandom_range(3);
      if (kind == 3 && g != groups - 1) kind = 0;
      if (kind == 2 && uu) kind = 0;
      if (kind == 3) nchars = uu ? $urandom_range(1, 3) : $urandom_range(2, 3);
      else if (kind == 2) nchars = $urandom_range(2, 3);
      else nchars = 4;
      repeat (nchars) msg.push_back(sb.char_at($urandom_range(63)));
      if (kind == 2) repeat (4 - nchars) msg.push_back(b64_pkg::PAD_CHAR);
    end
    r = $urandom_range(99);
    if (r < 12) begin
      msg[$urandom_range(msg.size() - 1)] = 8'($urandom_range(255));
    end else if (r < 18) begin
      msg.delete();
      repeat ($urandom_range(1, 6)) begin
        case ($urandom_range(2))
          0:       msg.push_back(b64_pkg::PAD_CHAR);
          1:       msg.push_back(sb.char_at($urandom_range(63)));
          default: msg.push_back(8'($urandom_range(255)));
        endcase
      end
    end
  endtask

  initial begin : stimulus
    int         phase;
    int         phase_len;
    int         phase_start;
    int         pick;
    logic [3:0] variant;
    logic       dir;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: unknown variant code behaves as the standard table.
    set_mode(4'hF, b64_pkg::DIR_ENCODE);
    msg = '{8'h00, 8'hFF, 8'h7F};
    send_msg();
    msg = '{8'hA5};
    send_msg();
    msg = '{8'h5A, 8'hC3};
    send_msg();
    set_mode(b64_pkg::VAR_MIME, b64_pkg::DIR_ENCODE);
    msg = '{8'hFF};
    send_msg();
    set_mode(b64_pkg::VAR_STD, b64_pkg::DIR_DECODE);
    send_text("TWFu");
    send_text("TQ==");
    send_text("TQ=A");
    // A high byte is invalid; the rest of that message is dropped.
    msg = '{8'hC1, "x"};
    send_msg();
    send_text("Q");
    // Leave a group half full; the next register write aborts it.
    send_beat("T", 1'b0);
    send_beat("W", 1'b0);
    set_mode(b64_pkg::VAR_UUENCODE, b64_pkg::DIR_DECODE);
    send_text("!");

    sent_items = 0;
    phase = 0;
    while (sent_items < RANDOM_ITEMS) begin
      pick = $urandom_range(11);
      if (pick < 9) variant = 4'(pick);
      else if (pick == 11) variant = 4'hF;
      else variant = 4'($urandom_range(9, 15));
      dir = 1'($urandom_range(1));
      if (phase == 5) dir = b64_pkg::DIR_ENCODE;
      phase_len = (phase == 3) ? 70 : $urandom_range(20, 60);
      set_mode(variant, dir);
      quiet = (phase == 3);
      if (phase == 5) hold_reqs++;
      phase_start = sent_items;
      while (sent_items - phase_start < phase_len && sent_items < RANDOM_ITEMS) begin
        if (dir == b64_pkg::DIR_ENCODE) build_plain();
        else build_encoded(variant);
        send_msg();
      end
      quiet = 1'b0;
      phase++;
    end

    wait_idle();
    repeat (4) @(negedge clk);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- base64_multi_alphabet_codec.f -----
+incdir+sv
sv/b64_pkg.sv
sv/b64_core.sv
sv/b64_obuf.sv
sv/base64_multi_alphabet_codec.sv
verif/tb.sv
